/* rtl/core/huffman_code_bit_packer_defines.svh */
// assertion macros used by the huffman code bit packer rtl
`ifndef HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define HCBP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcbp: same-cycle check failed");

`define HCBP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hcbp: next-cycle check failed");

`else

`define HCBP_ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define HCBP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/hcbp_pkg.sv */
// types and constants of the huffman code bit packer
package hcbp_pkg;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   localparam int SymW        = 9;
   localparam int CodeW       = 16;
   localparam int ByteW       = 8;
   localparam int OpW         = 2;
   localparam int MaxCodeBits = 15;
   localparam int LenW        = 4;
   localparam int PendW       = 7;
   localparam int AccW        = PendW + MaxCodeBits;
   localparam int CntW        = $clog2(AccW + 1);
   localparam int ReqDataW    = ((SymW + CodeW + 7) / 8) * 8;

endpackage

/* rtl/core/huffman_code_bit_packer.sv */
// huffman code bit packer: code table memory, lookup stage and byte emitter
//
// one request channel (req_*) carries three kinds of request in req_tuser:
// load writes one code table entry, encode looks up a symbol and appends its
// code bits msb first, finish appends the end-of-stream code and pads the
// remaining bits into a last byte. results leave on rsp_* one byte each,
// rsp_tuser flags a symbol without a usable code, rsp_tlast marks the final
// result of a request.
// a request's first result passes the lookup stage, the emitter's bit
// accumulator and the output register. the emitter sends one result per
// cycle while rsp_tready is high, up to two for an encode and three for a
// finish; the single byte-wide result port sets that rate.
// after reset the table is swept to zero, one entry per cycle, with
// req_tready low until all NUM_ENTRIES entries are cleared.
// results sit in an output register; while rsp_tready is low the emitter
// holds and one more request waits in the lookup stage before req_tready
// drops.
`include "huffman_code_bit_packer_defines.svh"

module huffman_code_bit_packer #(
   parameter int NUM_ENTRIES = 257
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [8:0] symbol, [24:9] code_word, [31:25] zero
   input  logic [hcbp_pkg::ReqDataW-1:0]     req_tdata,
   // [1:0] op
   input  logic [hcbp_pkg::OpW-1:0]          req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] out_byte
   output logic [hcbp_pkg::ByteW-1:0]        rsp_tdata,
   // [0] error
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int AW = $clog2(NUM_ENTRIES);
   localparam int AccW = hcbp_pkg::AccW;
   localparam int CntW = hcbp_pkg::CntW;
   localparam int CodeW = hcbp_pkg::CodeW;
   localparam int LenW = hcbp_pkg::LenW;
   localparam int PendW = hcbp_pkg::PendW;
   localparam logic [AW-1:0] EosAddr = AW'(NUM_ENTRIES - 1);
   localparam logic [CntW-1:0] ByteCnt = CntW'(hcbp_pkg::ByteW);

   // request fields
   logic [hcbp_pkg::SymW-1:0] req_symbol;
   logic [CodeW-1:0]          req_code_word;
   logic [AW+8:0]             sym_ext;
   logic [AW-1:0]             sym_addr;
   logic                      sym_in_range;
   logic                      req_accept;
   logic                      is_load;
   logic                      is_lookup;
   logic                      is_finish;

   assign req_symbol    = req_tdata[hcbp_pkg::SymW-1:0];
   assign req_code_word = req_tdata[hcbp_pkg::SymW+CodeW-1:hcbp_pkg::SymW];
   assign sym_ext       = (AW + 9)'(req_symbol);
   assign sym_addr      = sym_ext[AW-1:0];
   assign sym_in_range  = 32'(req_symbol) < 32'(NUM_ENTRIES);
   assign req_accept    = req_tvalid && req_tready;

   always_comb begin
      is_load   = 1'b0;
      is_lookup = 1'b0;
      is_finish = 1'b0;
      unique case (req_tuser)
         hcbp_pkg::OP_LOAD:   is_load = 1'b1;
         hcbp_pkg::OP_ENCODE: is_lookup = 1'b1;
         hcbp_pkg::OP_FINISH: begin
            is_lookup = 1'b1;
            is_finish = 1'b1;
         end
         default: ;
      endcase
   end

   // clearing sweep after reset
   logic          clr_active_ff, clr_active_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == EosAddr) begin
            clr_active_in = 1'b0;
         end
      end
   end

   // code table memory
   logic [CodeW-1:0] code_mem [NUM_ENTRIES];
   logic [CodeW-1:0] rd_data_ff;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [CodeW-1:0] wr_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;

   always_comb begin
      if (clr_active_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = req_accept && is_load && sym_in_range;
         wr_addr = sym_addr;
         wr_data = req_code_word;
      end
      rd_en   = req_accept && is_lookup;
      rd_addr = is_finish ? EosAddr : sym_addr;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         code_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= code_mem[rd_addr];
      end
   end

   // lookup stage
   logic s1_valid_ff, s1_valid_in;
   logic s1_finish_ff, s1_finish_in;
   logic s1_oob_ff, s1_oob_in;

   // emitter state: bit accumulator, bit count, pending error, flush
   logic [AccW-1:0] acc_ff, acc_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            err_pend_ff, err_pend_in;
   logic            flush_ff, flush_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [hcbp_pkg::ByteW-1:0] rsp_byte_ff, rsp_byte_in;
   logic                       rsp_err_ff, rsp_err_in;
   logic                       rsp_last_ff, rsp_last_in;

   // emission of one result
   logic                       out_free;
   logic                       work;
   logic                       emit_en;
   logic                       emit_last;
   logic [hcbp_pkg::ByteW-1:0] emit_byte;
   logic                       emit_err;
   logic [AccW-1:0]            shr_wide;
   logic [14:0]                pad_wide;
   logic [CntW-1:0]            cnt_after;
   logic [CntW-1:0]            post_cnt;
   logic                       post_err;
   logic                       post_idle;
   logic                       load_en;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign work     = err_pend_ff || (cnt_ff >= ByteCnt) || (flush_ff && cnt_ff != '0);
   assign emit_en  = work && out_free;
   assign shr_wide = acc_ff >> (cnt_ff - ByteCnt);
   assign pad_wide = 15'(acc_ff[PendW-1:0]) << (4'd8 - 4'(cnt_ff));

   always_comb begin
      emit_byte = '0;
      emit_err  = 1'b0;
      cnt_after = cnt_ff;
      priority if (err_pend_ff) begin
         emit_err  = 1'b1;
         emit_last = !((cnt_ff >= ByteCnt) || (flush_ff && cnt_ff != '0));
      end else if (cnt_ff >= ByteCnt) begin
         emit_byte = shr_wide[7:0];
         cnt_after = cnt_ff - ByteCnt;
         emit_last = !((cnt_after >= ByteCnt) || (flush_ff && cnt_after != '0));
      end else begin
         // zero-padded tail byte of a finish
         emit_byte = pad_wide[7:0];
         cnt_after = '0;
         emit_last = 1'b1;
      end
      post_cnt  = emit_en ? cnt_after : cnt_ff;
      post_err  = err_pend_ff && !emit_en;
      post_idle = !work || (emit_en && emit_last);
   end

   assign load_en    = s1_valid_ff && post_idle;
   assign req_tready = !clr_active_ff && (!s1_valid_ff || load_en);

   // code length from the leading sentinel one, then append
   logic [CodeW-1:0] word;
   logic [LenW-1:0]  len;
   logic             bad;
   logic [CodeW-1:0] code;
   logic [AccW-1:0]  appended;

   always_comb begin
      word = s1_oob_ff ? '0 : rd_data_ff;
      len  = '0;
      for (int i = 1; i < CodeW; i++) begin
         if (word[i]) begin
            len = LenW'(i);
         end
      end
      bad      = (word == '0) || (32'(len) > hcbp_pkg::MaxCodeBits);
      code     = word & ~(CodeW'(1) << len);
      appended = (AccW'(acc_ff[PendW-1:0]) << len) | AccW'(code);
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_finish_in = s1_finish_ff;
      s1_oob_in    = s1_oob_ff;
      if (load_en) begin
         s1_valid_in = 1'b0;
      end
      if (req_accept && is_lookup) begin
         s1_valid_in  = 1'b1;
         s1_finish_in = is_finish;
         s1_oob_in    = !is_finish && !sym_in_range;
      end

      acc_in      = acc_ff;
      cnt_in      = post_cnt;
      err_pend_in = post_err;
      flush_in    = flush_ff;
      if (load_en) begin
         err_pend_in = bad;
         flush_in    = s1_finish_ff;
         if (!bad) begin
            acc_in = appended;
            cnt_in = post_cnt + CntW'(len);
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_en) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_err_in   = emit_err;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         cnt_ff        <= '0;
         err_pend_ff   <= 1'b0;
         flush_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
         cnt_ff        <= cnt_in;
         err_pend_ff   <= err_pend_in;
         flush_ff      <= flush_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      s1_finish_ff <= s1_finish_in;
      s1_oob_ff    <= s1_oob_in;
      acc_ff       <= acc_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_last_ff;

   `HCBP_ASSERT_IMPLY(a_no_req_while_clearing, clock, reset, clr_active_ff, !req_tready)
   `HCBP_ASSERT_IMPLY(a_idle_holds_partial_byte, clock, reset, load_en, post_cnt < ByteCnt)
   `HCBP_ASSERT_NEXT(a_lookup_held_on_stall, clock, reset, s1_valid_ff && !load_en, s1_valid_ff)
   `HCBP_ASSERT_IMPLY(a_error_byte_zero, clock, reset, rsp_valid_ff && rsp_err_ff, rsp_byte_ff == '0)

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the huffman code bit packer
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumEntries = 257;
   localparam int NumRandom  = 185;
   localparam int CalmTail   = 40;
   localparam int QuietLimit = 3000;
   localparam int HoldOff    = 300;
   localparam int DrainWait  = 16;
   localparam int PlanLen    = 25;
   localparam int AccW       = hcbp_pkg::AccW;
   localparam int ReqDataW   = hcbp_pkg::ReqDataW;
   localparam logic [1:0] OpReserved = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic       err;
      logic       last;
   } emitted_byte_type;

   typedef struct packed {
      logic             fixed;
      emitted_byte_type val;
   } req_note_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [8:0]  sym;
      logic [15:0] cw;
      logic        fixed;
      logic [7:0]  rbyte;
      logic        rerr;
   } plan_row_type;

   // directed requests; fixed rows carry a single result typed in by hand
   plan_row_type plan [PlanLen] = '{
      '{hcbp_pkg::OP_ENCODE, 9'd0, 16'h0000, 1'b1, 8'h00, 1'b1},  // empty table
      '{hcbp_pkg::OP_FINISH, 9'd0, 16'h0000, 1'b1, 8'h00, 1'b1},  // no end code, none pending
      '{hcbp_pkg::OP_ENCODE, 9'd511, 16'hFFFF, 1'b1, 8'h00, 1'b1},  // symbol out of range
      '{hcbp_pkg::OP_LOAD, 9'd300, 16'hFFFF, 1'b0, 8'h00, 1'b0},  // load out of range
      '{OpReserved, 9'd511, 16'hFFFF, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_LOAD, 9'd0, 16'hFFFF, 1'b0, 8'h00, 1'b0},  // longest code, all ones
      '{hcbp_pkg::OP_LOAD, 9'd255, 16'h0001, 1'b0, 8'h00, 1'b0},  // sentinel only
      '{hcbp_pkg::OP_ENCODE, 9'd255, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_LOAD, 9'd256, 16'h0002, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_LOAD, 9'd1, 16'h01A5, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_ENCODE, 9'd1, 16'h0000, 1'b1, 8'hA5, 1'b0},  // one whole byte
      '{hcbp_pkg::OP_ENCODE, 9'd0, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_ENCODE, 9'd0, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_FINISH, 9'd0, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_LOAD, 9'd2, 16'h8000, 1'b0, 8'h00, 1'b0},  // longest code, all zeros
      '{hcbp_pkg::OP_ENCODE, 9'd2, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_ENCODE, 9'd2, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_LOAD, 9'd256, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_ENCODE, 9'd0, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_FINISH, 9'd0, 16'h0000, 1'b0, 8'h00, 1'b0},  // error then pad byte
      '{hcbp_pkg::OP_LOAD, 9'd256, 16'h8001, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_ENCODE, 9'd0, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_FINISH, 9'd0, 16'h0000, 1'b0, 8'h00, 1'b0},  // three results
      '{hcbp_pkg::OP_LOAD, 9'd0, 16'h0000, 1'b0, 8'h00, 1'b0},
      '{hcbp_pkg::OP_ENCODE, 9'd0, 16'h0000, 1'b1, 8'h00, 1'b1}   // entry cleared again
   };

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [ReqDataW-1:0]           req_tdata  = '0;
   logic [hcbp_pkg::OpW-1:0]      req_tuser  = hcbp_pkg::OP_LOAD;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b1;
   logic [hcbp_pkg::ByteW-1:0]    rsp_tdata;
   logic                          rsp_tuser;
   logic                          rsp_tlast;

   huffman_code_bit_packer #(.NUM_ENTRIES(NumEntries)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // packer state as the block should hold it
   logic [15:0]      code_mem [NumEntries];
   logic [AccW-1:0]  carry_bits;
   int unsigned      carry_cnt;
   emitted_byte_type new_bytes [$];
   emitted_byte_type bytes_due [$];
   req_note_type     req_notes [$];
   int               mismatches = 0;
   int               reqs_taken = 0;
   int               quiet      = 0;
   bit               calm       = 1'b0;

   task automatic emit(input logic [7:0] b, input logic e);
      new_bytes.push_back('{data: b, err: e, last: 1'b0});
   endtask

   task automatic append_entry(input int unsigned idx);
      logic [15:0] word;
      int unsigned len;
      int unsigned sh;
      if (idx >= NumEntries) begin
         emit(8'h00, 1'b1);
         return;
      end
      word = code_mem[idx];
      len = 0;
      for (int i = 1; i < 16; i++) if (word[i]) len = i;
      if (word == 16'h0000 || len > hcbp_pkg::MaxCodeBits) begin
         emit(8'h00, 1'b1);
         return;
      end
      carry_bits = (carry_bits << len) | AccW'(word ^ (16'd1 << len));
      carry_cnt += len;
      while (carry_cnt >= 8) begin
         sh = carry_cnt - 8;
         emit(8'(carry_bits >> sh), 1'b0);
         carry_cnt = sh;
         carry_bits &= (AccW'(1) << sh) - AccW'(1);
      end
   endtask

   task automatic pack_request(input logic [1:0] op, input logic [8:0] sym,
                               input logic [15:0] cw);
      new_bytes.delete();
      unique case (op)
         hcbp_pkg::OP_LOAD: begin
            if (sym < NumEntries) code_mem[sym] = cw;
         end
         hcbp_pkg::OP_ENCODE: begin
            append_entry(32'(sym));
         end
         hcbp_pkg::OP_FINISH: begin
            append_entry(NumEntries - 1);
            if (carry_cnt > 0) emit(8'(carry_bits << (8 - carry_cnt)), 1'b0);
            carry_bits = '0;
            carry_cnt = 0;
         end
         default: ;
      endcase
      if (new_bytes.size() > 0) new_bytes[new_bytes.size() - 1].last = 1'b1;
   endtask

   task automatic flag_bad(input string what, input emitted_byte_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t %s: expected data %02h err %0b last %0b, got %02h err %0b last %0b",
                  $realtime, what, want.data, want.err, want.last,
                  rsp_tdata, rsp_tuser, rsp_tlast);
   endtask

   // request and result monitor
   always @(posedge clock) begin
      req_note_type     note;
      emitted_byte_type want;
      if (reset) begin
         foreach (code_mem[i]) code_mem[i] = '0;
         carry_bits = '0;
         carry_cnt = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            reqs_taken++;
            pack_request(req_tuser, req_tdata[8:0], req_tdata[24:9]);
            note = req_notes.pop_front();
            if (note.fixed) bytes_due.push_back(note.val);
            else foreach (new_bytes[i]) bytes_due.push_back(new_bytes[i]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (bytes_due.size() == 0) begin
               flag_bad("unexpected byte", '0);
            end else begin
               want = bytes_due.pop_front();
               if (rsp_tdata !== want.data || rsp_tuser !== want.err || rsp_tlast !== want.last)
                  flag_bad("byte mismatch", want);
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
         if (quiet >= QuietLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // result side: short random stalls plus one long hold-off to back up the block
   initial begin
      bit held_off;
      held_off = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_off && reqs_taken >= 60) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HoldOff) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic offer(input logic [1:0] op, input logic [8:0] sym, input logic [15:0] cw,
                        input req_note_type note);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ReqDataW'({cw, sym});
      req_notes.push_back(note);
      do @(posedge clock); while (!req_tready);
   endtask

   // request side: directed table, then random traffic
   initial begin
      int           counted;
      int           pick;
      int           len;
      logic [1:0]   op;
      logic [8:0]   sym;
      logic [15:0]  cw;
      int           live_syms [$];
      req_note_type note;

      do @(posedge clock); while (reset);

      for (int r = 0; r < PlanLen; r++) begin
         note.fixed = plan[r].fixed;
         note.val = '{data: plan[r].rbyte, err: plan[r].rerr, last: 1'b1};
         offer(plan[r].op, plan[r].sym, plan[r].cw, note);
      end

      note = '0;
      counted = 0;
      while (counted < NumRandom) begin
         pick = $urandom_range(0, 99);
         sym = 9'($urandom);
         cw = 16'($urandom);
         if (pick < 22 || (live_syms.size() < 8 && pick < 60)) begin
            op = hcbp_pkg::OP_LOAD;
            sym = ($urandom_range(0, 19) == 0) ? 9'($urandom_range(257, 511))
                                               : 9'($urandom_range(0, 256));
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               cw = 16'h0000;
            end else if (pick == 1) begin
               cw = 16'h0001;
            end else begin
               len = $urandom_range(1, 15);
               cw = 16'((32'd1 << len) | ($urandom & ((32'd1 << len) - 1)));
            end
            if (sym < NumEntries && cw > 16'h0001) live_syms.push_back(int'(sym));
         end else if (pick < 80) begin
            op = hcbp_pkg::OP_ENCODE;
            if (live_syms.size() > 0 && $urandom_range(0, 9) != 0)
               sym = 9'(live_syms[$urandom_range(0, live_syms.size() - 1)]);
         end else if (pick < 92) begin
            op = hcbp_pkg::OP_FINISH;
         end else if (pick < 96) begin
            op = OpReserved;
         end else begin
            op = 2'($urandom_range(0, 3));
         end
         counted++;
         calm = (counted >= NumRandom - CalmTail);
         offer(op, sym, cw, note);
      end
      req_tvalid <= 1'b0;

      while (bytes_due.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      mismatches += bytes_due.size();

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/hcbp_pkg.sv
rtl/core/huffman_code_bit_packer.sv
tb/tb_top.sv
